// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the decoder RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LSTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lstd_pkg.sv -----
// Shared types and constants of the three-character range decoder.
// No dependencies.
package lstd_pkg;

  localparam int RANGE_W       = 18;
  localparam int STEP_W        = 10;
  localparam int ANGLE_STEP_W  = 18;
  localparam int ANGLE_OFS_W   = 26;
  localparam int ANGLE_W       = 22;
  localparam int ANGLE_SHIFT   = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 26;

  localparam logic [7:0] LF_BYTE      = 8'd10;
  localparam logic [7:0] CHAR_BIAS    = 8'd48;
  localparam logic [1:0] HEADER_LINES = 2'd3;
  localparam logic [1:0] LAST_PHASE   = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [RANGE_W-1:0]      MIN_RANGE_RST    = 18'd20;
  localparam logic [STEP_W-1:0]       FIRST_STEP_RST   = 10'd86;
  localparam logic [STEP_W-1:0]       LAST_STEP_RST    = 10'd596;
  localparam logic [ANGLE_STEP_W-1:0] ANGLE_STEP_RST   = 18'd103042;
  localparam logic [ANGLE_OFS_W-1:0]  ANGLE_OFS_RST    = 26'd8784529;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE,
    REG_FIRST_STEP,
    REG_LAST_STEP,
    REG_ANGLE_STEP,
    REG_ANGLE_OFFSET
  } reg_idx_t;

  typedef struct packed {
    logic [RANGE_W-1:0]      min_range;
    logic [STEP_W-1:0]       first_step;
    logic [STEP_W-1:0]       last_step;
    logic [ANGLE_STEP_W-1:0] angle_step;
    logic [ANGLE_OFS_W-1:0]  angle_offset;
  } cfg_t;

  typedef struct packed {
    logic               is_end;
    logic [RANGE_W-1:0] raw;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t entry;
  } push_t;

endpackage

// ----- rtl/core/lstd_in_if.sv -----
// Byte input channel of the decoder.
// Depends on nothing.
interface lstd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/lstd_out_if.sv -----
// Result channel of the decoder.
// Depends on nothing.
interface lstd_out_if;
  logic               valid;
  logic               ready;
  logic [17:0]        range_mm;
  logic [9:0]         step_index;
  logic signed [21:0] angle_q16;
  logic               end_of_scan;

  modport source (output valid, output range_mm, output step_index, output angle_q16,
                  output end_of_scan, input ready);
  modport sink (input valid, input range_mm, input step_index, input angle_q16,
                input end_of_scan, output ready);
endinterface

// ----- rtl/core/lidar_scan_three_char_decoder.sv -----
// Path: the byte that completes a result (the byte after its third character) writes it into
// the queue, from which it moves through the stage-A register to the output register.
// Throughput: one byte per cycle, one result per cycle while out_ch.ready is high; in_ready
// drops only while the four-entry queue is full. One step-counter by 18-bit multiply per step
// (10x18 by default). Reset: synchronous, active-low rst_n clears scan state and the queue and
// loads the configuration defaults.
module lidar_scan_three_char_decoder #(
  parameter int MAX_STEPS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lstd_in_if.sink                              in_ch,
  lstd_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [lstd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lstd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  lstd_pkg::cfg_t    cfg_r, cfg_nxt;
  lstd_pkg::push_t   push;
  lstd_pkg::qentry_t head;
  logic              head_valid, full, pop, accept;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lstd_pkg::REG_MIN_RANGE:    cfg_nxt.min_range    = cfg_wdata[lstd_pkg::RANGE_W-1:0];
        lstd_pkg::REG_FIRST_STEP:   cfg_nxt.first_step   = cfg_wdata[lstd_pkg::STEP_W-1:0];
        lstd_pkg::REG_LAST_STEP:    cfg_nxt.last_step    = cfg_wdata[lstd_pkg::STEP_W-1:0];
        lstd_pkg::REG_ANGLE_STEP:   cfg_nxt.angle_step   = cfg_wdata[lstd_pkg::ANGLE_STEP_W-1:0];
        lstd_pkg::REG_ANGLE_OFFSET: cfg_nxt.angle_offset = cfg_wdata[lstd_pkg::ANGLE_OFS_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range    <= lstd_pkg::MIN_RANGE_RST;
      cfg_r.first_step   <= lstd_pkg::FIRST_STEP_RST;
      cfg_r.last_step    <= lstd_pkg::LAST_STEP_RST;
      cfg_r.angle_step   <= lstd_pkg::ANGLE_STEP_RST;
      cfg_r.angle_offset <= lstd_pkg::ANGLE_OFS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lstd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .push    (push)
  );

  lstd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  lstd_back #(
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .entry       (head),
    .entry_valid (head_valid),
    .pop         (pop),
    .out         (out_ch)
  );

endmodule

// ----- rtl/core/lstd_front.sv -----
// Front end: header skip, checksum drop, character grouping and end-of-scan markers.
// Depends on lstd_pkg.
module lstd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  output lstd_pkg::push_t push
);

  logic [1:0]  hdr_r, hdr_nxt;
  logic        lf_r, lf_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_vld_r, held_vld_nxt;
  logic [11:0] grp_r, grp_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  unbiased;
  logic [5:0]  digit;

  assign unbiased = held_r - lstd_pkg::CHAR_BIAS;
  assign digit    = unbiased[5:0];

  always_comb begin
    hdr_nxt      = hdr_r;
    lf_nxt       = lf_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    grp_nxt      = grp_r;
    phase_nxt    = phase_r;
    push         = '0;
    if (accept) begin
      if (hdr_r < lstd_pkg::HEADER_LINES) begin
        lf_nxt = (rx_byte == lstd_pkg::LF_BYTE);
        if (rx_byte == lstd_pkg::LF_BYTE) begin
          hdr_nxt = hdr_r + 2'd1;
        end
      end else if (rx_byte == lstd_pkg::LF_BYTE) begin
        if (lf_r) begin
          // blank line: end marker, fresh scan
          push.valid        = 1'b1;
          push.entry.is_end = 1'b1;
          hdr_nxt           = '0;
          lf_nxt            = 1'b0;
          held_nxt          = '0;
          held_vld_nxt      = 1'b0;
          grp_nxt           = '0;
          phase_nxt         = '0;
        end else begin
          // held char is the checksum
          held_vld_nxt = 1'b0;
          lf_nxt       = 1'b1;
        end
      end else begin
        lf_nxt = 1'b0;
        if (held_vld_r) begin
          if (phase_r < lstd_pkg::LAST_PHASE) begin
            grp_nxt   = {grp_r[5:0], digit};
            phase_nxt = phase_r + 2'd1;
          end else begin
            push.valid     = 1'b1;
            push.entry.raw = {grp_r, digit};
            grp_nxt        = '0;
            phase_nxt      = '0;
          end
        end
        held_nxt     = rx_byte;
        held_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= '0;
      lf_r       <= 1'b0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      grp_r      <= '0;
      phase_r    <= '0;
    end else begin
      hdr_r      <= hdr_nxt;
      lf_r       <= lf_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      grp_r      <= grp_nxt;
      phase_r    <= phase_nxt;
    end
  end

endmodule

// ----- rtl/core/lstd_fifo.sv -----
// Short queue between front and back end.
// Depends on lstd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lstd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  lstd_pkg::push_t   push,
  input  logic              pop,
  output lstd_pkg::qentry_t head,
  output logic              head_valid,
  output logic              full
);

  localparam logic [lstd_pkg::QPTR_W:0] DEPTH_CNT = (lstd_pkg::QPTR_W + 1)'(lstd_pkg::QDEPTH);

  lstd_pkg::qentry_t           mem_r [lstd_pkg::QDEPTH];
  logic [lstd_pkg::QPTR_W-1:0] wr_r, wr_nxt;
  logic [lstd_pkg::QPTR_W-1:0] rd_r, rd_nxt;
  logic [lstd_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  assign head       = mem_r[rd_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == DEPTH_CNT);

  always_comb begin
    wr_nxt  = push.valid ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `LSTD_ASSERT_NOW(a_no_push_full, push.valid, !full, "push into full queue")
  `LSTD_ASSERT_NOW(a_no_pop_empty, pop, head_valid, "pop from empty queue")
  `LSTD_ASSERT_NEXT(a_cnt_track, push.valid && !pop, cnt_r == $past(cnt_r) + 1'b1, "count lost push")

endmodule

// ----- rtl/core/lstd_back.sv -----
// Back end: range filter, step window, angle multiply and output register.
// Depends on lstd_pkg, lstd_out_if and assert_macros.svh.
`include "assert_macros.svh"

module lstd_back #(
  parameter int MAX_STEPS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lstd_pkg::cfg_t    cfg,
  input  lstd_pkg::qentry_t entry,
  input  logic              entry_valid,
  output logic              pop,
  lstd_out_if.source        out
);

  localparam int CNT_W = $clog2(MAX_STEPS);
  localparam int SW    = (CNT_W > lstd_pkg::STEP_W) ? CNT_W : lstd_pkg::STEP_W;
  localparam int PW    = CNT_W + lstd_pkg::ANGLE_STEP_W;
  localparam int DW    = ((PW > lstd_pkg::ANGLE_OFS_W + 4) ? PW : lstd_pkg::ANGLE_OFS_W + 4) + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_STEPS - 1);

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [lstd_pkg::RANGE_W-1:0] lgr_r, lgr_nxt;
  logic                        a_vld_r, a_vld_nxt;
  logic                        a_end_r;
  logic [lstd_pkg::RANGE_W-1:0] a_range_r;
  logic [lstd_pkg::STEP_W-1:0] a_step_r;
  logic [PW-1:0]               a_prod_r;
  logic                        out_vld_r, out_vld_nxt;
  logic [lstd_pkg::RANGE_W-1:0] out_range_r;
  logic [lstd_pkg::STEP_W-1:0] out_step_r;
  logic signed [lstd_pkg::ANGLE_W-1:0] out_angle_r;
  logic                        out_end_r;

  logic                        b_load, a_free, in_win, good;
  logic [SW-1:0]               step_ext;
  logic [lstd_pkg::RANGE_W-1:0] filt;
  logic signed [DW-1:0]        diff;

  assign b_load   = a_vld_r && (!out_vld_r || out.ready);
  assign a_free   = !a_vld_r || b_load;
  assign pop      = entry_valid && a_free;
  assign step_ext = SW'(cnt_r);
  assign in_win   = (step_ext >= SW'(cfg.first_step)) && (step_ext <= SW'(cfg.last_step));
  assign good     = entry.raw > cfg.min_range;
  assign filt     = good ? entry.raw : lgr_r;
  assign diff     = $signed(DW'(a_prod_r)) - $signed(DW'(cfg.angle_offset));

  assign out.valid       = out_vld_r;
  assign out.range_mm    = out_range_r;
  assign out.step_index  = out_step_r;
  assign out.angle_q16   = out_angle_r;
  assign out.end_of_scan = out_end_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    lgr_nxt   = lgr_r;
    a_vld_nxt = a_vld_r;
    if (pop) begin
      a_vld_nxt = entry.is_end || in_win;
      if (entry.is_end) begin
        cnt_nxt = '0;
        lgr_nxt = cfg.min_range;
      end else begin
        cnt_nxt = (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;
        if (good) begin
          lgr_nxt = entry.raw;
        end
      end
    end else if (b_load) begin
      a_vld_nxt = 1'b0;
    end
    out_vld_nxt = b_load ? 1'b1 : (out.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_end_r   <= entry.is_end;
      a_range_r <= entry.is_end ? '0 : filt;
      a_step_r  <= step_ext[lstd_pkg::STEP_W-1:0];
      a_prod_r  <= PW'(cnt_r) * PW'(cfg.angle_step);
    end
    if (b_load) begin
      out_range_r <= a_range_r;
      out_step_r  <= a_step_r;
      out_end_r   <= a_end_r;
      out_angle_r <= a_end_r ? '0 : diff[lstd_pkg::ANGLE_SHIFT +: lstd_pkg::ANGLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      lgr_r     <= lstd_pkg::MIN_RANGE_RST;
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      lgr_r     <= lgr_nxt;
      a_vld_r   <= a_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  `LSTD_ASSERT_NEXT(a_scan_restart, pop && entry.is_end, cnt_r == '0 && lgr_r == $past(cfg.min_range), "scan state not restarted")
  `LSTD_ASSERT_NEXT(a_stage_hold, a_vld_r && !b_load, a_vld_r, "stage A item dropped")
  `LSTD_ASSERT_NOW(a_marker_zero, out_vld_r && out_end_r, out_range_r == '0 && out_angle_r == '0, "end marker carries data")

endmodule
